### src/gapf_pkg.sv
`timescale 1ns / 1ps
package gapf_pkg;

  localparam int GRID_SIZE  = 16;
  localparam int COORD_W    = 4;
  localparam int CELL_W     = 2 * COORD_W;
  localparam int NODE_W     = CELL_W + 2;
  localparam int NODE_COUNT = 1 << NODE_W;
  localparam int CNT_W      = NODE_W + 1;
  localparam int COST_W     = 10;
  localparam int F_W        = 11;

  localparam logic [1:0] FLAG_OPEN   = 2'd1;
  localparam logic [1:0] FLAG_CLOSED = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_COST,
    S_SCAN_CMP,
    S_REMOVE_RD,
    S_REMOVE_WR,
    S_EXPAND,
    S_NB_RD,
    S_NB_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_TRACE_RD,
    S_TRACE,
    S_STORE_RD,
    S_STORE,
    S_READ_RD,
    S_READ,
    S_OUT
  } state_t;

endpackage

### src/grid_astar_path_finder_top.sv
`timescale 1ns / 1ps
// A* path finder over a 16 x 16 grid with four headings per cell. Each item
// gives one result item. After reset in_tready stays low while the map is
// swept free. A map write or the spare command has its result item set up in
// S_OUT after it is accepted, and a path step read in S_READ_RD and S_READ.
// A search is run by one sequencer over single-port node memories: a clearing
// pass over the node flags, then for each node popped a linear scan of the
// open list, a removal shift of each later entry and a check of each
// neighbor (plus a search of the open list to find a reopened node), then a
// walk over the parent chain twice. The open-list scan sets the run time of
// a search. in_tready is low while an item is worked and while its result
// item waits.
module grid_astar_path_finder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], cell_row[5:2], cell_column[9:6], cell_blocked[10],
  // start_row[14:11], start_column[18:15], start_heading[20:19],
  // goal_row[24:21], goal_column[28:25], goal_heading[30:29], step_index[40:31]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // path_length[9:0], step_row[13:10], step_column[17:14],
  // step_heading[19:18], index_invalid[20]
  output logic [23:0] out_tdata
);
  import gapf_pkg::*;

  // Memories.
  logic             map_mem [0:(1<<CELL_W)-1];
  logic [NODE_W-1:0] order_mem [0:NODE_COUNT-1];
  logic [1:0]       flag_mem [0:NODE_COUNT-1];
  logic [COST_W-1:0] cost_mem [0:NODE_COUNT-1];
  logic [NODE_W-1:0] par_mem [0:NODE_COUNT-1];
  logic [NODE_W-1:0] path_mem [0:NODE_COUNT-1];

  state_t state_r, state_nxt;
  logic [47:0] item_r, item_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;       // open count
  logic [CNT_W-1:0] idx_r, idx_nxt;       // general index
  logic [CNT_W-1:0] best_k_r, best_k_nxt;
  logic [F_W-1:0] best_f_r, best_f_nxt;
  logic best_v_r, best_v_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt, nd_r, nd_nxt, x_r, x_nxt;
  logic [COST_W-1:0] curg_r, curg_nxt;
  logic [1:0] mv_r, mv_nxt;
  logic [CNT_W-1:0] slen_r, slen_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [23:0] res_r, res_nxt;
  logic        outv_r, outv_nxt;

  // Memory ports (one access per memory per cycle).
  logic             map_we;
  logic [CELL_W-1:0] map_a;
  logic             map_q;
  logic             ord_we;
  logic [NODE_W-1:0] ord_a, ord_d, ord_q;
  logic             flg_we;
  logic [NODE_W-1:0] flg_a;
  logic [1:0]       flg_d, flg_q;
  logic             cst_we;
  logic [NODE_W-1:0] cst_a;
  logic [COST_W-1:0] cst_d, cst_q;
  logic             par_we;
  logic [NODE_W-1:0] par_a, par_d, par_q;
  logic             pth_we;
  logic [NODE_W-1:0] pth_a, pth_d, pth_q;

  // Map cells come out of reset free: a clearing pass sweeps the map once.
  logic map_d_w;
  logic clr_done_r, clr_done_nxt;
  logic [CELL_W-1:0] clr_a_r, clr_a_nxt;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_a] <= map_d_w;
    map_q <= map_mem[map_a];
    if (ord_we) order_mem[ord_a] <= ord_d;
    ord_q <= order_mem[ord_a];
    if (flg_we) flag_mem[flg_a] <= flg_d;
    flg_q <= flag_mem[flg_a];
    if (cst_we) cost_mem[cst_a] <= cst_d;
    cst_q <= cost_mem[cst_a];
    if (par_we) par_mem[par_a] <= par_d;
    par_q <= par_mem[par_a];
    if (pth_we) path_mem[pth_a] <= pth_d;
    pth_q <= path_mem[pth_a];
  end

  // Item fields.
  logic [COORD_W-1:0] s_row, s_col, g_row, g_col;
  logic [1:0] s_hd, g_hd;
  logic [9:0] s_idx;
  logic [NODE_W-1:0] s_node, g_node;
  assign s_row = item_r[14:11];
  assign s_col = item_r[18:15];
  assign s_hd  = item_r[20:19];
  assign g_row = item_r[24:21];
  assign g_col = item_r[28:25];
  assign g_hd  = item_r[30:29];
  assign s_idx = item_r[40:31];
  assign s_node = {s_row, s_col, s_hd};
  assign g_node = {g_row, g_col, g_hd};

  // Heuristic and F unit on the node just read.
  logic [COORD_W-1:0] h_r, h_c, dr, dc;
  logic [F_W-1:0] f_val;
  assign h_r = nd_r[NODE_W-1 -: COORD_W];
  assign h_c = nd_r[NODE_W-1-COORD_W -: COORD_W];
  assign dr = (h_r > g_row) ? h_r - g_row : g_row - h_r;
  assign dc = (h_c > g_col) ? h_c - g_col : g_col - h_c;
  assign f_val = F_W'(cst_q) + F_W'(dr) + F_W'(dc);

  // Neighbor generation for the current node.
  logic [COORD_W-1:0] cr, cc, nr, nc;
  logic [1:0] ch;
  logic fwd_ok;
  assign cr = cur_r[NODE_W-1 -: COORD_W];
  assign cc = cur_r[NODE_W-1-COORD_W -: COORD_W];
  assign ch = cur_r[1:0];
  always_comb begin
    nr = cr;
    nc = cc;
    fwd_ok = 1'b0;
    unique case (ch)
      2'd0: begin fwd_ok = (cr != '0); nr = cr - 1'b1; end
      2'd1: begin fwd_ok = (cr != COORD_W'(GRID_SIZE-1)); nr = cr + 1'b1; end
      2'd2: begin fwd_ok = (cc != '0); nc = cc - 1'b1; end
      default: begin fwd_ok = (cc != COORD_W'(GRID_SIZE-1)); nc = cc + 1'b1; end
    endcase
  end

  logic [9:0] len_sat;
  assign len_sat = (slen_r > CNT_W'(1023)) ? 10'd1023 : slen_r[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      slen_r <= '0;
      outv_r <= 1'b0;
      clr_done_r <= 1'b0;
      clr_a_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      slen_r <= slen_nxt;
      outv_r <= outv_nxt;
      clr_done_r <= clr_done_nxt;
      clr_a_r <= clr_a_nxt;
    end
    item_r <= item_nxt;
    idx_r <= idx_nxt;
    best_k_r <= best_k_nxt;
    best_f_r <= best_f_nxt;
    best_v_r <= best_v_nxt;
    cur_r <= cur_nxt;
    nd_r <= nd_nxt;
    x_r <= x_nxt;
    curg_r <= curg_nxt;
    mv_r <= mv_nxt;
    len_r <= len_nxt;
    res_r <= res_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && clr_done_r && !outv_r;
  assign out_tvalid = outv_r;
  assign out_tdata  = res_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    best_k_nxt = best_k_r;
    best_f_nxt = best_f_r;
    best_v_nxt = best_v_r;
    cur_nxt = cur_r;
    nd_nxt = nd_r;
    x_nxt = x_r;
    curg_nxt = curg_r;
    mv_nxt = mv_r;
    slen_nxt = slen_r;
    len_nxt = len_r;
    res_nxt = res_r;
    outv_nxt = outv_r;
    clr_done_nxt = clr_done_r;
    clr_a_nxt = clr_a_r;
    map_we = 1'b0; map_a = '0; map_d_w = 1'b0;
    ord_we = 1'b0; ord_a = '0; ord_d = '0;
    flg_we = 1'b0; flg_a = '0; flg_d = '0;
    cst_we = 1'b0; cst_a = '0; cst_d = '0;
    par_we = 1'b0; par_a = '0; par_d = '0;
    pth_we = 1'b0; pth_a = '0; pth_d = '0;

    if (outv_r && out_tready) outv_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!clr_done_r) begin
          // Map clearing pass after reset.
          map_we = 1'b1;
          map_a = clr_a_r;
          clr_a_nxt = clr_a_r + 1'b1;
          if (clr_a_r == '1) clr_done_nxt = 1'b1;
        end else if (in_tvalid && in_tready) begin
          item_nxt = in_tdata;
          priority case (cmd_t'(in_tdata[1:0]))
            CMD_SEARCH: begin
              idx_nxt = '0;
              cnt_nxt = '0;
              slen_nxt = '0;
              state_nxt = S_CLEAR;
            end
            CMD_READ: state_nxt = S_READ_RD;
            default: state_nxt = S_OUT;
          endcase
          if (cmd_t'(in_tdata[1:0]) == CMD_WRITE) begin
            map_we = 1'b1;
            map_a = {in_tdata[5:2], in_tdata[9:6]};
            map_d_w = in_tdata[10];
          end
        end
      end
      // Clear node flags, then seed the open list with the start pose.
      S_CLEAR: begin
        flg_we = 1'b1;
        flg_a = idx_r[NODE_W-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CNT_W'(NODE_COUNT-1)) begin
          state_nxt = S_IDLE;
          ord_we = 1'b1; ord_a = '0; ord_d = s_node;
          cst_we = 1'b1; cst_a = s_node; cst_d = '0;
          cnt_nxt = CNT_W'(1);
          state_nxt = S_SCAN_RD;
          idx_nxt = '0;
          best_v_nxt = 1'b0;
        end
      end
      // Open list scan for the earliest entry with the least F.
      S_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          idx_nxt = best_k_r;
          state_nxt = S_REMOVE_RD;
          ord_a = best_k_r[NODE_W-1:0];
        end else begin
          ord_a = idx_r[NODE_W-1:0];
          state_nxt = S_SCAN_COST;
        end
      end
      S_SCAN_COST: begin
        cst_a = ord_q;
        nd_nxt = ord_q;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (!best_v_r || f_val < best_f_r) begin
          best_v_nxt = 1'b1;
          best_f_nxt = f_val;
          best_k_nxt = idx_r;
          cur_nxt = nd_r;
          curg_nxt = cst_q;
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_SCAN_RD;
      end
      // Shift later entries down over the removed slot, then close the node.
      S_REMOVE_RD: begin
        if (idx_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          flg_we = 1'b1; flg_a = cur_r; flg_d = FLAG_CLOSED;
          if (cur_r == g_node) begin
            len_nxt = '0;
            nd_nxt = g_node;
            state_nxt = S_TRACE;
          end else begin
            mv_nxt = '0;
            state_nxt = S_EXPAND;
          end
        end else begin
          ord_a = idx_r[NODE_W-1:0] + 1'b1;
          state_nxt = S_REMOVE_WR;
        end
      end
      S_REMOVE_WR: begin
        ord_we = 1'b1; ord_a = idx_r[NODE_W-1:0]; ord_d = ord_q;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_REMOVE_RD;
      end
      // Pick the next move and read what it needs.
      S_EXPAND: begin
        unique case (mv_r)
          2'd0: begin
            x_nxt = {cr, cc, (ch[1] ? 2'd0 : 2'd2)};
            state_nxt = S_NB_RD;
          end
          2'd1: begin
            x_nxt = {cr, cc, (ch[1] ? 2'd1 : 2'd3)};
            state_nxt = S_NB_RD;
          end
          2'd2: begin
            x_nxt = {nr, nc, ch};
            map_a = {nr, nc};
            state_nxt = fwd_ok ? S_NB_RD : S_SCAN_RD;
          end
          default: state_nxt = S_SCAN_RD;
        endcase
        if (mv_r == 2'd2 && !fwd_ok) begin
          state_nxt = (cnt_r == '0) ? S_OUT : S_SCAN_RD;
          idx_nxt = '0;
          best_v_nxt = 1'b0;
        end
        mv_nxt = mv_r + 1'b1;
      end
      // The map cell is read again here so that it is valid in the check.
      S_NB_RD: begin
        flg_a = x_r;
        cst_a = x_r;
        map_a = x_r[NODE_W-1:2];
        state_nxt = S_NB_CHK;
      end
      S_NB_CHK: begin
        if ((mv_r == 2'd3 && map_q) || flg_q[1]) begin
          state_nxt = S_EXPAND;
        end else if (flg_q[0]) begin
          if (cst_q > curg_r + 1'b1) begin
            idx_nxt = '0;
            state_nxt = S_FIND_RD;
          end else begin
            state_nxt = S_EXPAND;
          end
        end else begin
          ord_we = 1'b1; ord_a = cnt_r[NODE_W-1:0]; ord_d = x_r;
          cnt_nxt = cnt_r + 1'b1;
          flg_we = 1'b1; flg_a = x_r; flg_d = FLAG_OPEN;
          cst_we = 1'b1; cst_a = x_r; cst_d = curg_r + 1'b1;
          par_we = 1'b1; par_a = x_r; par_d = cur_r;
          state_nxt = S_EXPAND;
        end
        if (state_nxt == S_EXPAND && mv_r == 2'd3) begin
          idx_nxt = '0;
          best_v_nxt = 1'b0;
          state_nxt = (cnt_nxt == '0) ? S_OUT : S_SCAN_RD;
        end
      end
      // Locate the reopened node, then shift it to the tail of the open list.
      S_FIND_RD: begin
        ord_a = idx_r[NODE_W-1:0];
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (ord_q == x_r) begin
          state_nxt = S_STORE_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_FIND_RD;
        end
      end
      S_STORE_RD: begin
        if (idx_r + 1'b1 >= cnt_r) begin
          ord_we = 1'b1; ord_a = idx_r[NODE_W-1:0]; ord_d = x_r;
          cst_we = 1'b1; cst_a = x_r; cst_d = curg_r + 1'b1;
          par_we = 1'b1; par_a = x_r; par_d = cur_r;
          if (mv_r == 2'd3) begin
            idx_nxt = '0;
            best_v_nxt = 1'b0;
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_EXPAND;
          end
        end else begin
          ord_a = idx_r[NODE_W-1:0] + 1'b1;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        ord_we = 1'b1; ord_a = idx_r[NODE_W-1:0]; ord_d = ord_q;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_STORE_RD;
      end
      // Parent walk: first count, then store back to front.
      S_TRACE: begin
        if (nd_r == s_node || len_r == CNT_W'(NODE_COUNT)) begin
          if (best_v_r) begin
            state_nxt = S_OUT;
          end else begin
            slen_nxt = len_r;
            best_v_nxt = 1'b1;
            nd_nxt = g_node;
          end
        end else begin
          par_a = nd_r;
          state_nxt = S_TRACE_RD;
        end
      end
      S_TRACE_RD: begin
        if (best_v_r) begin
          pth_we = 1'b1;
          pth_a = NODE_W'(len_r - 1'b1);
          pth_d = nd_r;
          len_nxt = len_r - 1'b1;
          if (len_r == CNT_W'(1)) nd_nxt = s_node;
          else nd_nxt = par_q;
        end else begin
          len_nxt = len_r + 1'b1;
          nd_nxt = par_q;
        end
        state_nxt = S_TRACE;
        if (best_v_r && len_r == CNT_W'(1)) state_nxt = S_OUT;
      end
      S_READ_RD: begin
        pth_a = s_idx[NODE_W-1:0];
        state_nxt = S_READ;
      end
      S_READ: begin
        res_nxt = '0;
        res_nxt[9:0] = len_sat;
        if (CNT_W'(s_idx) < slen_r) begin
          res_nxt[13:10] = pth_q[NODE_W-1 -: COORD_W];
          res_nxt[17:14] = pth_q[NODE_W-1-COORD_W -: COORD_W];
          res_nxt[19:18] = pth_q[1:0];
        end else begin
          res_nxt[20] = 1'b1;
        end
        outv_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        res_nxt = '0;
        res_nxt[9:0] = len_sat;
        outv_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Entry to the parent walk from the removal step needs best_v cleared.
    if (state_r == S_REMOVE_RD && state_nxt == S_TRACE) best_v_nxt = 1'b0;
  end

endmodule
